### hdl/gcct_pkg.sv
// Shared constants, register and mode codes, and control types for the grid cell coverage tracker.
`default_nettype none

package gcct_pkg;

    // Storage limit for the visited bitmap.
    localparam int GCCT_MAX_CELLS = 256;

    // Field widths.
    localparam int COORD_W   = 13;
    localparam int DIM_W     = 12;
    localparam int GRID_N_W  = 5;
    localparam int CELLS_W   = 10;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 24;
    localparam int TOTAL_W   = 9;
    localparam int INDEX_W   = 8;

    // The bitmap is stored as words of this many cells.
    localparam int ROW_W     = 8;
    localparam int ROW_SEL_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd5;

    // Register reset values.
    localparam logic [GRID_N_W-1:0] RST_ROWS   = 5'd4;
    localparam logic [GRID_N_W-1:0] RST_COLS   = 5'd4;
    localparam logic [DIM_W-1:0]    RST_WIDTH  = 12'd1280;
    localparam logic [DIM_W-1:0]    RST_HEIGHT = 12'd720;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic geom_start;
        logic geom_latch;
        logic axis_start;
        logic look;
        logic rd;
        logic upd;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic geom_dirty;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### hdl/gcct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gcct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/gcct_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module gcct_div
    import gcct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIM_W-1:0] i_num,
    input  wire logic [DIM_W-1:0] i_den,
    output logic      [DIM_W-1:0] o_quo,
    output logic                  o_done
);

    localparam int STEP_W = $clog2(DIM_W + 1);

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_quo;
    logic [DIM_W-1:0]  r_den;
    logic [DIM_W:0]    shifted;
    logic              take;
    logic [DIM_W-1:0]  n_rem;
    logic [DIM_W-1:0]  n_quo;

    // One shift-and-subtract step.
    always_comb begin
        shifted = {r_rem, r_quo[DIM_W-1]};
        take    = (shifted >= {1'b0, r_den});
        n_rem   = take ? DIM_W'(shifted - {1'b0, r_den}) : shifted[DIM_W-1:0];
        n_quo   = {r_quo[DIM_W-2:0], take};
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b1;
        end else if (i_start) begin
            r_cnt  <= STEP_W'(DIM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

### hdl/gcct_datapath.sv
// Datapath: configuration, cell geometry dividers, classification, visited bitmap and result.
`default_nettype none

module gcct_datapath
    import gcct_pkg::*;
#(
    parameter int MAX_CELLS = GCCT_MAX_CELLS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic [IN_W-1:0]      i_in_data,
    input  wire logic [MODE_W-1:0]    i_in_user,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [OUT_W-1:0]     o_out_data
);

    localparam int NUM_ROWS = (MAX_CELLS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int LANES    = 4;
    localparam int DIFF_W   = COORD_W + 1;

    // Configuration registers.
    logic [GRID_N_W-1:0] r_rows;
    logic [GRID_N_W-1:0] r_cols;
    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [DIM_W-1:0]    r_org_x;
    logic [DIM_W-1:0]    r_org_y;
    logic                r_dirty;

    // Item and geometry registers.
    logic [MODE_W-1:0]         r_mode;
    logic signed [COORD_W-1:0] r_pt [LANES];
    logic [DIM_W-1:0]          r_cw;
    logic [DIM_W-1:0]          r_ch;
    logic [LANES-1:0]          r_neg;
    logic                      r_found;
    logic [CELLS_W-1:0]        r_idx;

    // Bitmap state.
    logic [NUM_ROWS-1:0] r_vld;
    logic [CNT_W-1:0]    r_cnt;

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [DIFF_W-1:0] diff    [LANES];
    logic [DIM_W-1:0]  div_num [LANES];
    logic [DIM_W-1:0]  div_den [LANES];
    logic [DIM_W-1:0]  quo     [LANES];
    logic [LANES-1:0]  done;
    logic [LANES-1:0]  axis_ok;

    logic [CELLS_W-1:0]   cells;
    logic                 grid_ok;
    logic                 found_n;
    logic [CELLS_W-1:0]   idx_n;
    logic                 clear_marks;
    logic [CELLS_W-1:0]   row_full;
    logic [ROW_AW-1:0]    row_addr;
    logic [ROW_SEL_W-1:0] bit_sel;
    logic [ROW_W-1:0]     rd_word;
    logic [ROW_W-1:0]     word;
    logic [ROW_W-1:0]     wr_word;
    logic                 was;
    logic                 mark;
    logic [CNT_W-1:0]     cnt_next;
    logic                 all_n;

    // Grid size and its validity.
    assign cells   = CELLS_W'(r_rows) * CELLS_W'(r_cols);
    assign grid_ok = (cells != '0) && (32'(cells) <= 32'(MAX_CELLS));

    // Marks are emptied by clear mode and by any change of the cell counts.
    assign clear_marks = (i_cmd.load && (i_in_user == MODE_CLEAR)) ||
                         (i_cfg_we && ((i_cfg_addr == CFG_ROWS) || (i_cfg_addr == CFG_COLS)));

    // Configuration writes; a geometry write forces the cell size to be recomputed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= RST_ROWS;
            r_cols   <= RST_COLS;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_dirty  <= 1'b1;
        end else begin
            if (i_cmd.geom_latch) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ROWS: begin
                        r_rows  <= i_cfg_data[GRID_N_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    CFG_COLS: begin
                        r_cols  <= i_cfg_data[GRID_N_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    CFG_WIDTH: begin
                        r_width <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    CFG_HEIGHT: begin
                        r_height <= i_cfg_data;
                        r_dirty  <= 1'b1;
                    end
                    CFG_ORIGIN_X: begin
                        r_org_x <= i_cfg_data;
                    end
                    CFG_ORIGIN_Y: begin
                        r_org_y <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture of the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_user;
            for (int l = 0; l < LANES; l++) begin
                r_pt[l] <= i_in_data[l*COORD_W +: COORD_W];
            end
        end
    end

    // Divider lanes: x lanes use columns and cell width, y lanes rows and cell height.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam bit IS_X = (l % 2 == 0);

        assign diff[l] = {r_pt[l][COORD_W-1], r_pt[l]} -
                         {2'b00, (IS_X ? r_org_x : r_org_y)};

        assign div_num[l] = i_cmd.geom_start ? (IS_X ? r_width : r_height)
                                             : diff[l][DIM_W-1:0];
        assign div_den[l] = i_cmd.geom_start ? DIM_W'(IS_X ? r_cols : r_rows)
                                             : (IS_X ? r_cw : r_ch);

        assign axis_ok[l] = !r_neg[l] && ((IS_X ? r_cw : r_ch) != '0) &&
                            (quo[l] < DIM_W'(IS_X ? r_cols : r_rows));

        gcct_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.geom_start | i_cmd.axis_start),
            .i_num   (div_num[l]),
            .i_den   (div_den[l]),
            .o_quo   (quo[l]),
            .o_done  (done[l])
        );
    end

    // Cell size and point side flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.geom_latch) begin
            r_cw <= quo[0];
            r_ch <= quo[1];
        end
        if (i_cmd.axis_start) begin
            for (int l = 0; l < LANES; l++) begin
                r_neg[l] <= diff[l][DIFF_W-1];
            end
        end
    end

    // Both points must land in the same cell of a valid grid.
    assign found_n = grid_ok && (&axis_ok) && (quo[0] == quo[2]) && (quo[1] == quo[3]);
    assign idx_n   = CELLS_W'(quo[1][GRID_N_W-1:0]) * CELLS_W'(r_cols) +
                     CELLS_W'(quo[0][GRID_N_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_found <= found_n;
            r_idx   <= found_n ? idx_n : '0;
        end
    end

    // Bitmap word addressing.
    assign row_full = CELLS_W'(r_idx >> ROW_SEL_W);
    assign row_addr = row_full[ROW_AW-1:0];
    assign bit_sel  = r_idx[ROW_SEL_W-1:0];

    gcct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (mark),
        .i_wr_addr (row_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (row_addr),
        .o_rd_data (rd_word)
    );

    // Read-modify-write of the visited word; a word not yet written reads as empty.
    always_comb begin
        word     = r_vld[row_addr] ? rd_word : '0;
        was      = r_found && word[bit_sel];
        mark     = i_cmd.upd && r_found && (r_mode == MODE_MARK) && !was;
        wr_word  = word | (ROW_W'(1) << bit_sel);
        cnt_next = mark ? r_cnt + 1'b1 : r_cnt;
        all_n    = grid_ok && (32'(cnt_next) == 32'(cells));
    end

    // Word valid bits and the visited count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else if (clear_marks) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else if (mark) begin
            r_vld[row_addr] <= 1'b1;
            r_cnt           <= cnt_next;
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_data <= {4'b0000, all_n, TOTAL_W'(cnt_next), was,
                           INDEX_W'(r_idx), r_found};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.geom_dirty = r_dirty;
    assign o_status.div_done   = &done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // A new mark adds exactly one to the count.
    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mark |=> r_cnt == CNT_W'($past(r_cnt) + 1'b1))
        else $error("visited count did not follow a new mark");

    // Clear mode leaves an empty bitmap and a zero count.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (i_in_user == MODE_CLEAR)) |=> (r_cnt == '0) && (r_vld == '0))
        else $error("clear mode left marks behind");

    // A found cell lies inside the grid.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && r_found) |-> (32'(r_idx) < 32'(cells)))
        else $error("found cell index outside the grid");

    // A result waiting for the receiver is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.upd)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### hdl/gcct_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module gcct_ctrl
    import gcct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_GEOM_W = 3'd2;
    localparam logic [2:0] S_AXIS   = 3'd3;
    localparam logic [2:0] S_AXIS_W = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_UPD    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                // Cell size is recomputed only after reset or a geometry write.
                if (i_status.geom_dirty) begin
                    o_cmd.geom_start = 1'b1;
                    n_state          = S_GEOM_W;
                end else begin
                    o_cmd.axis_start = 1'b1;
                    n_state          = S_AXIS_W;
                end
            end
            S_GEOM_W: begin
                if (i_status.div_done) begin
                    o_cmd.geom_latch = 1'b1;
                    n_state          = S_AXIS;
                end
            end
            S_AXIS: begin
                o_cmd.axis_start = 1'b1;
                n_state          = S_AXIS_W;
            end
            S_AXIS_W: begin
                if (i_status.div_done) begin
                    o_cmd.look = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/grid_cell_coverage_tracker.sv
// Grid cell coverage tracker: classifies point pairs into grid cells and tracks visited cells.
//
// Input stream: tuser carries the mode (classify, mark, clear); tdata carries the two
// points. Each input transfer yields exactly one output transfer with found, cell index,
// was-visited flag, visited total and the all-visited flag.
// Configuration: one write channel with register index and data, always ready; the user must
// write while no item is in flight; not enforced. Row or column count writes empty the marks.
// Timing: an item is accepted only once the previous item has left its final step; four
// 12-bit restoring dividers, one quotient bit per cycle, find its cell. The first item
// after reset or after a write of rows, columns, width or height takes longer while the
// dividers first recompute the cell size.
// The visited bitmap sits in a RAM of 8-cell words with one valid flag per word, so reset
// and clear take effect at once without a clearing pass.
// A stalled receiver holds the result in the output register; the next item is accepted
// meanwhile and waits at its final step until the register frees.
`default_nettype none

module grid_cell_coverage_tracker
    import gcct_pkg::*;
#(
    parameter int MAX_CELLS = GCCT_MAX_CELLS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // first_x, first_y, second_x, second_y (13 bits each), zero fill
    input  wire logic [IN_W-1:0]      i_s_axis_tdata,
    // mode
    input  wire logic [MODE_W-1:0]    i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // found, cell_index (8), was_visited, visited_total (9), all_visited, zero fill
    output logic      [OUT_W-1:0]     o_m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    gcct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gcct_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
